@@ rtl/core/lkvc_pkg.sv @@
package lkvc_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 16;
   localparam int VALUE_BITS = 32;
   localparam int CAP_BITS   = 5;
   localparam int CNT_BITS   = $clog2(ENTRIES + 1);
   localparam int CMP_BITS   = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(ENTRIES);

   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_PUT = 1'b1;

   // one stored pair, also the word handed from cell to cell
   typedef struct packed {
      logic                  valid;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   typedef struct packed {
      logic apply;       // item accepted this cycle
      logic hit;         // key found somewhere in the row
      logic miss_shift;  // this cell moves on a put of a new key
   } cell_ctl_type;

endpackage

@@ rtl/core/lkvc_cell.sv @@
module lkvc_cell
   import lkvc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [KEY_BITS-1:0]   req_key,
   input  cell_ctl_type          ctl,
   input  entry_type             prev_entry,
   input  logic                  match_in,
   input  logic [VALUE_BITS-1:0] hit_value_in,
   output entry_type             entry,
   output logic                  match_out,
   output logic [VALUE_BITS-1:0] hit_value_out
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      match;
   logic      shift;

   assign match         = entry_ff.valid && (entry_ff.key == req_key);
   // match_out is high when the hit sits in this cell or further down the row
   assign match_out     = match | match_in;
   assign hit_value_out = hit_value_in | (match ? entry_ff.value : '0);

   // on a hit, every cell up to the hit cell ages; on a new key, the row
   // up to the fill limit ages and, when full, the oldest word drops off the end
   assign shift    = ctl.apply && (ctl.hit ? match_out : ctl.miss_shift);
   assign entry_in = shift ? prev_entry : entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.key   <= entry_in.key;
      entry_ff.value <= entry_in.value;
   end

   assign entry = entry_ff;

endmodule

@@ rtl/core/lru_key_value_cache_core.sv @@
// Response: a request accepted at a clock edge shows its response, with
// rsp_valid high, during the following cycle; busy stays low.
// Throughput: one request per cycle; the key compare and recency shift over
// the row of entry cells finish in the accept cycle.
// Reset: synchronous; empties the cache and sets capacity to 16.
// The response cannot be stalled.
module lru_key_value_cache_core
   import lkvc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_action,
   input  logic [KEY_BITS-1:0]          req_key,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic                         csr_wr_en,
   input  logic [CAP_BITS-1:0]          csr_wr_data,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output logic signed [VALUE_BITS-1:0] rsp_read_value
);

   logic [CAP_BITS-1:0]   csr_capacity_ff;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  rsp_valid_ff, rsp_hit_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;

   entry_type             entries [ENTRIES];
   entry_type             head;
   logic                  match_chain [ENTRIES+1];
   logic [VALUE_BITS-1:0] value_chain [ENTRIES+1];
   logic [ENTRIES-1:0]    valid_vec;

   logic                  hit;
   logic                  is_put;
   logic                  full;
   logic [CMP_BITS-1:0]   eff_cap;
   logic [CNT_BITS-1:0]   limit;

   assign busy   = 1'b0;
   assign is_put = (req_action == ACTION_PUT);
   assign hit    = match_chain[0];

   always_comb begin
      if (csr_capacity_ff == '0) begin
         eff_cap = CMP_BITS'(1);
      end else if (CMP_BITS'(csr_capacity_ff) > CMP_BITS'(ENTRIES)) begin
         eff_cap = CMP_BITS'(ENTRIES);
      end else begin
         eff_cap = CMP_BITS'(csr_capacity_ff);
      end
   end

   assign full  = (CMP_BITS'(count_ff) >= eff_cap);
   // last cell that moves on a new key: the oldest one when full, else the
   // first empty one
   assign limit = full ? (count_ff - CNT_BITS'(1)) : count_ff;

   assign head.valid = 1'b1;
   assign head.key   = req_key;
   assign head.value = is_put ? req_value : value_chain[0];

   assign match_chain[ENTRIES] = 1'b0;
   assign value_chain[ENTRIES] = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      cell_ctl_type ctl;
      entry_type    prev;

      assign ctl.apply      = start && !busy;
      assign ctl.hit        = hit;
      assign ctl.miss_shift = is_put && (CNT_BITS'(i) <= limit);

      if (i == 0) begin : g_head
         assign prev = head;
      end else begin : g_body
         assign prev = entries[i-1];
      end

      lkvc_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .req_key       (req_key),
         .ctl           (ctl),
         .prev_entry    (prev),
         .match_in      (match_chain[i+1]),
         .hit_value_in  (value_chain[i+1]),
         .entry         (entries[i]),
         .match_out     (match_chain[i]),
         .hit_value_out (value_chain[i])
      );

      assign valid_vec[i] = entries[i].valid;
   end

   always_comb begin
      count_in = count_ff;
      if (start && !busy && is_put && !hit && !full) begin
         count_in = count_ff + CNT_BITS'(1);
      end
   end

   assign rsp_value_in = (!is_put && hit) ? value_chain[0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_capacity_ff <= CAP_RESET;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_capacity_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff   <= hit;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

   // occupied cells are exactly the count
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == count_ff)
      else $error("valid cells disagree with entry count");

   // occupied cells are packed at the young end of the row
   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec & (valid_vec + ENTRIES'(1))) == '0))
      else $error("gap in occupied cells");

   // a hit needs a non-empty cache
   a_hit_needs_entry: assert property (@(posedge clock) disable iff (reset)
      (start && hit) |-> (count_ff != '0))
      else $error("hit on empty cache");

   // a put of a new key never leaves the count unchanged unless full
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (start && is_put && !hit && !full) |=> (count_ff == $past(count_ff) + CNT_BITS'(1)))
      else $error("count did not advance on insert");

endmodule

@@ tb/lkvc_checker.sv @@
module lkvc_checker
   import lkvc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic                         req_action,
   input  logic [KEY_BITS-1:0]          req_key,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic                         csr_wr_en,
   input  logic [CAP_BITS-1:0]          csr_wr_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_hit,
   input  logic signed [VALUE_BITS-1:0] rsp_read_value,
   output int                           mismatch_count,
   output int                           pending_words
);

   typedef struct packed {
      logic                         hit;
      logic signed [VALUE_BITS-1:0] read_value;
   } lookup_answer_type;

   // mirror of the cache contents, each slot tagged with its recency rank
   logic [KEY_BITS-1:0]   mirror_key   [ENTRIES];
   logic [VALUE_BITS-1:0] mirror_value [ENTRIES];
   logic                  mirror_valid [ENTRIES];
   logic [3:0]            mirror_rank  [ENTRIES];
   logic [CNT_BITS-1:0]   mirror_count;
   logic [CAP_BITS-1:0]   mirror_capacity;

   lookup_answer_type lookup_answers[$];

   // make slot s the most recent; every younger valid slot ages by one
   task automatic make_recent(input int s);
      logic [3:0] r;
      r = mirror_rank[s];
      for (int i = 0; i < ENTRIES; i++)
         if (mirror_valid[i] && i != s && mirror_rank[i] < r)
            mirror_rank[i] = mirror_rank[i] + 4'd1;
      mirror_rank[s] = 4'd0;
   endtask

   task automatic cache_lookup(input logic act, input logic [KEY_BITS-1:0] k,
                               input logic [VALUE_BITS-1:0] v,
                               output lookup_answer_type ans);
      int         found;
      int         free_slot;
      int         oldest;
      int         limit;
      bit         seen;
      logic [3:0] oldest_rank;
      found     = -1;
      free_slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (found < 0 && mirror_valid[i] && mirror_key[i] == k) found = i;
         if (free_slot < 0 && !mirror_valid[i]) free_slot = i;
      end
      ans.hit        = (found >= 0);
      ans.read_value = '0;
      if (act == ACTION_GET) begin
         if (found >= 0) begin
            ans.read_value = mirror_value[found];
            make_recent(found);
         end
      end else if (found >= 0) begin
         mirror_value[found] = v;
         make_recent(found);
      end else begin
         limit = int'(mirror_capacity);
         if (limit == 0) limit = 1;
         if (limit > ENTRIES) limit = ENTRIES;
         if (int'(mirror_count) >= limit || free_slot < 0) begin
            // replace only the single oldest entry, count unchanged
            oldest      = 0;
            oldest_rank = 4'd0;
            seen        = 1'b0;
            for (int i = 0; i < ENTRIES; i++)
               if (mirror_valid[i] && (!seen || mirror_rank[i] > oldest_rank)) begin
                  oldest      = i;
                  oldest_rank = mirror_rank[i];
                  seen        = 1'b1;
               end
            mirror_key[oldest]   = k;
            mirror_value[oldest] = v;
            make_recent(oldest);
         end else begin
            for (int i = 0; i < ENTRIES; i++)
               if (mirror_valid[i]) mirror_rank[i] = mirror_rank[i] + 4'd1;
            mirror_valid[free_slot] = 1'b1;
            mirror_key[free_slot]   = k;
            mirror_value[free_slot] = v;
            mirror_rank[free_slot]  = 4'd0;
            mirror_count            = mirror_count + 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin
      lookup_answer_type want;
      lookup_answer_type fresh;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            mirror_valid[i] = 1'b0;
            mirror_rank[i]  = 4'd0;
            mirror_key[i]   = '0;
            mirror_value[i] = '0;
         end
         mirror_count    = '0;
         mirror_capacity = CAP_RESET;
         mismatch_count  = 0;
         lookup_answers.delete();
      end else begin
         // retire the word of an earlier accept before queuing this one
         if (rsp_valid) begin
            if (lookup_answers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: hit=%0b read_value=%0d", rsp_hit, rsp_read_value);
            end else begin
               want = lookup_answers.pop_front();
               if (rsp_hit !== want.hit || rsp_read_value !== want.read_value) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("bad word: hit exp %0b got %0b, read_value exp %0d got %0d",
                              want.hit, rsp_hit, want.read_value, rsp_read_value);
               end
            end
         end
         if (csr_wr_en) mirror_capacity = csr_wr_data;
         if (start && !busy) begin
            cache_lookup(req_action, req_key, req_value, fresh);
            lookup_answers = {lookup_answers, fresh};
         end
      end
      pending_words = lookup_answers.size();
   end

endmodule

@@ tb/lru_key_value_cache_core_tb.sv @@
module lru_key_value_cache_core_tb;
   import lkvc_pkg::*;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic                         req_action;
   logic [KEY_BITS-1:0]          req_key;
   logic signed [VALUE_BITS-1:0] req_value;
   logic                         csr_wr_en;
   logic [CAP_BITS-1:0]          csr_wr_data;
   logic                         rsp_valid;
   logic                         rsp_hit;
   logic signed [VALUE_BITS-1:0] rsp_read_value;
   int                           mismatch_count;
   int                           pending_words;

   bit                  sender_gaps;
   logic [KEY_BITS-1:0] key_pool [48];
   int                  pool_size;

   lru_key_value_cache_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_key        (req_key),
      .req_value      (req_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value)
   );

   lkvc_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_key        (req_key),
      .req_value      (req_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 200000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_word(input logic act, input logic [KEY_BITS-1:0] k,
                            input logic [VALUE_BITS-1:0] v);
      @(negedge clock);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      start      = 1'b1;
      req_action = act;
      req_key    = k;
      req_value  = v;
      do @(posedge clock); while (busy);
   endtask

   // hold the sender until every outstanding word has come back
   task automatic drain;
      @(negedge clock);
      start = 1'b0;
      while (pending_words != 0) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
      drain();
      csr_wr_en   = 1'b1;
      csr_wr_data = cap;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic run_phase(input logic [CAP_BITS-1:0] cap, input int count,
                            input bit with_pause);
      int         limit;
      logic       act;
      logic [KEY_BITS-1:0] k;
      write_capacity(cap);
      limit = int'(cap);
      if (limit == 0) limit = 1;
      if (limit > ENTRIES) limit = ENTRIES;
      // a pool of limit to 2*limit+2 keys keeps hits and evictions both common
      pool_size = limit + $urandom_range(0, limit + 2);
      for (int j = 0; j < pool_size; j++) key_pool[j] = KEY_BITS'($urandom_range(0, 65535));
      for (int n = 0; n < count; n++) begin
         if (with_pause && n == count / 2) drain();
         act = ($urandom_range(0, 99) < 45) ? ACTION_PUT : ACTION_GET;
         if ($urandom_range(0, 9) == 0) k = KEY_BITS'($urandom_range(0, 65535));
         else k = key_pool[$urandom_range(0, pool_size - 1)];
         send_word(act, k, $urandom);
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_action  = ACTION_GET;
      req_key     = '0;
      req_value   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      sender_gaps = 1'b0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // directed: empty miss, field extremes, update, eviction, shrunk capacity
      send_word(ACTION_GET, 16'h0000, 32'h0000_0000);
      send_word(ACTION_PUT, 16'h0000, 32'h8000_0000);
      send_word(ACTION_PUT, 16'hFFFF, 32'h7FFF_FFFF);
      send_word(ACTION_GET, 16'h0000, 32'hFFFF_FFFF);
      send_word(ACTION_GET, 16'hFFFF, 32'h0000_0000);
      send_word(ACTION_PUT, 16'h0000, 32'hFFFF_FFFF);
      send_word(ACTION_GET, 16'h0000, 32'h0000_0000);
      send_word(ACTION_GET, 16'h1234, 32'h5A5A_A5A5);
      write_capacity(5'd2);
      send_word(ACTION_PUT, 16'h0003, 32'h0000_0003);
      send_word(ACTION_GET, 16'hFFFF, 32'h0000_0000);
      send_word(ACTION_GET, 16'h0000, 32'h0000_0000);
      // capacity below the count: only the oldest entry is replaced
      write_capacity(5'd1);
      send_word(ACTION_PUT, 16'h0009, 32'h0000_0009);
      send_word(ACTION_GET, 16'h0000, 32'h0000_0000);
      send_word(ACTION_GET, 16'h0009, 32'h0000_0000);
      send_word(ACTION_GET, 16'h0003, 32'h0000_0000);
      send_word(ACTION_PUT, 16'h00AA, 32'h1234_5678);
      send_word(ACTION_GET, 16'h0009, 32'h0000_0000);

      sender_gaps = 1'b1;
      run_phase(5'd16, 140, 1'b0);
      run_phase(5'd1,  140, 1'b0);
      run_phase(5'd0,  140, 1'b0);
      run_phase(5'd31, 140, 1'b1);
      run_phase(5'd4,  140, 1'b0);
      run_phase(5'd9,  140, 1'b1);
      run_phase(5'd17, 140, 1'b0);
      run_phase(5'd2,  140, 1'b0);
      run_phase(5'd12, 140, 1'b0);
      sender_gaps = 1'b0;
      run_phase(5'd16, 140, 1'b0);

      drain();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0 && pending_words == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
